FILE: rtl/core/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ORS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ORS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/ors_pkg.sv
package ors_pkg;

  localparam int unsigned RomW = 64;
  localparam int unsigned PosW = 7;
  localparam int unsigned IdxW = 6;

  localparam logic [7:0] CMD_NORMAL_SEARCH = 8'hF0;
  localparam logic [7:0] CMD_ALARM_SEARCH  = 8'hEC;
  localparam logic [PosW-1:0] LAST_POS = 7'd64;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_FAMILY = 2'd1,
    KIND_BEGIN  = 2'd2,
    KIND_BIT    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic       presence;
    logic       alarm_search;
    logic       id_bit;
    logic       complement_bit;
    logic [7:0] family_code;
  } item_t;

  typedef struct packed {
    logic [RomW-1:0] rom_bits;
    logic [PosW-1:0] last_discrepancy;
    logic            last_device;
    logic [PosW-1:0] bit_position;
    logic [PosW-1:0] last_zero;
    logic            pass_active;
  } state_t;

  typedef struct packed {
    logic            send_command;
    logic [7:0]      command_byte;
    logic            send_bit;
    logic            write_bit;
    logic            pass_done;
    logic            found;
    logic [RomW-1:0] rom_code;
  } result_t;

endpackage

FILE: rtl/core/ors_decide.sv
module ors_decide (
  input  ors_pkg::item_t   item_i,
  input  ors_pkg::state_t  state_i,
  output ors_pkg::state_t  state_o,
  output ors_pkg::result_t result_o
);

  always_comb begin
    logic [ors_pkg::PosW-1:0] pos;
    logic [ors_pkg::PosW-1:0] pos_m1;
    logic [ors_pkg::IdxW-1:0] idx;
    logic                     dir;
    logic [ors_pkg::RomW-1:0] rom_nxt;
    logic [ors_pkg::PosW-1:0] lz_nxt;

    state_o  = state_i;
    result_o = '0;
    pos      = state_i.bit_position;
    pos_m1   = pos - 7'd1;
    idx      = pos_m1[ors_pkg::IdxW-1:0];
    dir      = 1'b0;
    rom_nxt  = state_i.rom_bits;
    lz_nxt   = state_i.last_zero;

    unique case (item_i.kind)
      ors_pkg::KIND_CLEAR: begin
        state_o.rom_bits         = '0;
        state_o.last_discrepancy = '0;
        state_o.last_device      = 1'b0;
        state_o.pass_active      = 1'b0;
      end
      ors_pkg::KIND_FAMILY: begin
        state_o.rom_bits         = {{(ors_pkg::RomW-8){1'b0}}, item_i.family_code};
        state_o.last_discrepancy = ors_pkg::LAST_POS;
        state_o.last_device      = 1'b0;
        state_o.pass_active      = 1'b0;
      end
      ors_pkg::KIND_BEGIN: begin
        if (state_i.last_device || !item_i.presence) begin
          state_o.last_discrepancy = '0;
          state_o.last_device      = 1'b0;
          state_o.pass_active      = 1'b0;
          result_o.pass_done       = 1'b1;
        end else begin
          state_o.pass_active   = 1'b1;
          state_o.bit_position  = 7'd1;
          state_o.last_zero     = '0;
          result_o.send_command = 1'b1;
          result_o.command_byte = item_i.alarm_search ? ors_pkg::CMD_ALARM_SEARCH
                                                      : ors_pkg::CMD_NORMAL_SEARCH;
        end
      end
      ors_pkg::KIND_BIT: begin
        if (state_i.pass_active) begin
          if (item_i.id_bit && item_i.complement_bit) begin
            // Nobody answered this slot: the pass fails.
            state_o.last_discrepancy = '0;
            state_o.last_device      = 1'b0;
            state_o.pass_active      = 1'b0;
            result_o.pass_done       = 1'b1;
          end else begin
            if (item_i.id_bit != item_i.complement_bit) begin
              dir = item_i.id_bit;
            end else begin
              // Discrepancy: repeat the old path below the last fork, take
              // the one branch at it, the zero branch beyond it.
              if (pos < state_i.last_discrepancy) begin
                dir = state_i.rom_bits[idx];
              end else begin
                dir = (pos == state_i.last_discrepancy);
              end
              if (!dir) begin
                lz_nxt = pos;
              end
            end
            rom_nxt[idx]       = dir;
            state_o.rom_bits   = rom_nxt;
            state_o.last_zero  = lz_nxt;
            result_o.send_bit  = 1'b1;
            result_o.write_bit = dir;
            if (pos >= ors_pkg::LAST_POS) begin
              state_o.pass_active  = 1'b0;
              state_o.bit_position = 7'd1;
              result_o.pass_done   = 1'b1;
              if (rom_nxt[7:0] == 8'd0) begin
                state_o.last_discrepancy = '0;
                state_o.last_device      = 1'b0;
              end else begin
                state_o.last_discrepancy = lz_nxt;
                state_o.last_device      = (lz_nxt == '0);
                result_o.found           = 1'b1;
                result_o.rom_code        = rom_nxt;
              end
            end else begin
              state_o.bit_position = pos + 7'd1;
            end
          end
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

FILE: rtl/core/onewire_rom_search_engine.sv
// Search-ROM decision engine. Each input word goes into an input register,
// is decided combinationally against the search state, and its result word
// lands in an output register; one word per cycle is sustained while the
// output is not stalled, set by the single decision stage between the two
// registers. Every input word yields exactly one result word. After reset
// the ROM code, last discrepancy and last-device flag are zero and no pass
// is active.
`include "assert_macros.svh"

module onewire_rom_search_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic        presence_i,
  input  logic        alarm_search_i,
  input  logic        id_bit_i,
  input  logic        complement_bit_i,
  input  logic [7:0]  family_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        send_command_o,
  output logic [7:0]  command_byte_o,
  output logic        send_bit_o,
  output logic        write_bit_o,
  output logic        pass_done_o,
  output logic        found_o,
  output logic [63:0] rom_code_o
);

  logic              in_valid_q;
  ors_pkg::item_t    item_q;
  logic              out_valid_q;
  ors_pkg::result_t  res_q;
  ors_pkg::result_t  res_d;
  ors_pkg::state_t   state_q;
  ors_pkg::state_t   state_d;
  logic              advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.kind           <= ors_pkg::kind_e'(kind_i);
      item_q.presence       <= presence_i;
      item_q.alarm_search   <= alarm_search_i;
      item_q.id_bit         <= id_bit_i;
      item_q.complement_bit <= complement_bit_i;
      item_q.family_code    <= family_code_i;
    end
  end

  ors_decide u_decide (
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.rom_bits         <= '0;
      state_q.last_discrepancy <= '0;
      state_q.last_device      <= 1'b0;
      state_q.bit_position     <= 7'd1;
      state_q.last_zero        <= '0;
      state_q.pass_active      <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign send_command_o = res_q.send_command;
  assign command_byte_o = res_q.command_byte;
  assign send_bit_o     = res_q.send_bit;
  assign write_bit_o    = res_q.write_bit;
  assign pass_done_o    = res_q.pass_done;
  assign found_o        = res_q.found;
  assign rom_code_o     = res_q.rom_code;

  `ORS_ASSERT(a_cmd_bit_excl, out_valid_q |-> !(res_q.send_command && res_q.send_bit), "command and direction bit in one word")
  `ORS_ASSERT(a_found_done, (out_valid_q && res_q.found) |-> (res_q.pass_done && (res_q.rom_code[7:0] != 8'd0)), "found without a finished pass or with a zero family byte")
  `ORS_ASSERT(a_pos_range, state_q.pass_active |-> ((state_q.bit_position != '0) && (state_q.bit_position <= ors_pkg::LAST_POS)), "bit position out of range during a pass")
  `ORS_ASSERT(a_out_hold, (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(res_q)), "stalled result word changed")
  `ORS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (!out_valid_q && !in_valid_q), "word pending during reset")

endmodule
